[rtl/core/smu_pkg.sv]
`default_nettype none
package smu_pkg;

   // lattice geometry
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int SIZE_BITS  = 7;
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int LAT_DEPTH  = 1 << ADDR_BITS;

   // acceptance compare width
   localparam int PROB_BITS  = 16;
   localparam int THR_BITS   = 16;
   localparam int THR_WORDS  = 4;
   localparam int THR_PER_WD = 4;
   localparam int DE_MAX     = THR_WORDS * THR_PER_WD;

   // commands
   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_ROWS   = 3'd0;
   localparam logic [2:0] CSR_COLS   = 3'd1;
   localparam logic [2:0] CSR_VAC    = 3'd2;
   localparam logic [2:0] CSR_THR_A  = 3'd3;
   localparam logic [2:0] CSR_THR_B  = 3'd4;
   localparam logic [2:0] CSR_THR_C  = 3'd5;
   localparam logic [2:0] CSR_THR_D  = 3'd6;

   typedef logic [THR_WORDS-1:0][63:0] thr_bank_type;

   // outcome of one Metropolis decision
   typedef struct packed {
      logic signed [1:0] spin_new;
      logic              accepted;
      logic signed [5:0] energy_change;
   } decide_type;

endpackage
`default_nettype wire

[rtl/core/spin_one_metropolis_update_core.sv]
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  cmd, row, col, spin_in, step_bit, accept_random
// rsp_      out        rsp_valid/rsp_ready  spin_out, accepted, energy_change, site_error
// csr_      in         csr_we (no wait)     csr_index, csr_wdata
//
// An update: site read issued at the transfer, four neighbour reads through the one lattice
// port, then the decision, then hand over and write back of an accepted spin.
// A read passes through the fetch state; a write and a bad site go straight to the finish state.
// Synchronous reset clears control, presets configuration; lattice is undefined until written.
// A waiting result is held in the output register; the next item is still accepted and
// its result waits in the finish state until the output register is free.
module spin_one_metropolis_update_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [5:0]  req_row,
   input  wire logic [5:0]  req_col,
   input  wire logic signed [1:0] req_spin_in,
   input  wire logic        req_step_bit,
   input  wire logic [15:0] req_accept_random,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [1:0] rsp_spin_out,
   output logic             rsp_accepted,
   output logic signed [5:0] rsp_energy_change,
   output logic             rsp_site_error,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import smu_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   // configuration
   logic [SIZE_BITS-1:0] rows_ff, cols_ff;
   logic signed [4:0]    vac_ff;
   thr_bank_type         thr_ff;

   // control
   logic [1:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // item and result payload
   logic [1:0]           cmd_ff, cmd_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic                 step_ff, step_in;
   logic [15:0]          rnd_ff, rnd_in;
   logic signed [1:0]    old_ff, old_in;
   logic signed [3:0]    ns_ff, ns_in;
   logic signed [1:0]    res_spin_ff, res_spin_in;
   logic                 res_acc_ff, res_acc_in;
   logic signed [5:0]    res_de_ff, res_de_in;
   logic                 res_err_ff, res_err_in;
   logic signed [1:0]    out_spin_ff, out_spin_in;
   logic                 out_acc_ff, out_acc_in;
   logic signed [5:0]    out_de_ff, out_de_in;
   logic                 out_err_ff, out_err_in;

   // lattice memory
   logic [1:0]           lattice_mem [LAT_DEPTH];
   logic [1:0]           rdata_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   logic                 mem_we;
   logic [1:0]           mem_wdata;

   logic [SIZE_BITS-1:0] nr, nc;
   logic [ROW_BITS-1:0]  row_up, row_dn;
   logic [COL_BITS-1:0]  col_lf, col_rt;
   logic                 bad_site;
   logic signed [1:0]    spin_sat;
   logic signed [3:0]    ns_total;
   logic                 out_free;
   decide_type           dec;

   // effective sizes: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (rows_ff == '0) nr = SIZE_BITS'(1);
      else if (rows_ff > SIZE_BITS'(MAX_ROWS)) nr = SIZE_BITS'(MAX_ROWS);
      else nr = rows_ff;
      if (cols_ff == '0) nc = SIZE_BITS'(1);
      else if (cols_ff > SIZE_BITS'(MAX_COLS)) nc = SIZE_BITS'(MAX_COLS);
      else nc = cols_ff;
   end

   // wrapped neighbours of the held site
   always_comb begin
      row_up = (row_ff == '0) ? ROW_BITS'(nr - SIZE_BITS'(1)) : row_ff - ROW_BITS'(1);
      row_dn = ({1'b0, row_ff} + SIZE_BITS'(1) == nr) ? '0 : row_ff + ROW_BITS'(1);
      col_lf = (col_ff == '0) ? COL_BITS'(nc - SIZE_BITS'(1)) : col_ff - COL_BITS'(1);
      col_rt = ({1'b0, col_ff} + SIZE_BITS'(1) == nc) ? '0 : col_ff + COL_BITS'(1);
   end

   assign bad_site = ({1'b0, req_row} >= nr) || ({1'b0, req_col} >= nc);
   assign spin_sat = (req_spin_in == -2'sd2) ? -2'sd1 : req_spin_in;
   assign ns_total = ns_ff + 4'(signed'(rdata_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;

   smu_decide u_decide (
      .old_spin      (old_ff),
      .nbr_sum       (ns_total),
      .step_bit      (step_ff),
      .vacancy_cost  (vac_ff),
      .thresholds    (thr_ff),
      .accept_random (rnd_ff),
      .decision      (dec)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      rnd_in       = rnd_ff;
      old_in       = old_ff;
      ns_in        = ns_ff;
      res_spin_in  = res_spin_ff;
      res_acc_in   = res_acc_ff;
      res_de_in    = res_de_ff;
      res_err_in   = res_err_ff;
      out_spin_in  = out_spin_ff;
      out_acc_in   = out_acc_ff;
      out_de_in    = out_de_ff;
      out_err_in   = out_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_addr     = {row_ff, col_ff};
      mem_we       = 1'b0;
      mem_wdata    = res_spin_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // no transfer while reset is held
            req_ready = !reset;
            if (req_valid && req_ready) begin
               cmd_in      = req_cmd;
               row_in      = req_row;
               col_in      = req_col;
               step_in     = req_step_bit;
               rnd_in      = req_accept_random;
               res_acc_in  = 1'b0;
               res_de_in   = '0;
               res_err_in  = 1'b0;
               res_spin_in = '0;
               mem_addr    = {req_row, req_col};
               if (bad_site) begin
                  res_err_in = 1'b1;
                  state_in   = ST_DONE;
               end else if (req_cmd == CMD_WRITE) begin
                  mem_we      = 1'b1;
                  mem_wdata   = spin_sat;
                  res_spin_in = spin_sat;
                  state_in    = ST_DONE;
               end else begin
                  // centre read issued now
                  cnt_in   = 3'd1;
                  ns_in    = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd1: begin
                  old_in = rdata_ff;
                  if (cmd_ff != CMD_UPDATE) begin
                     res_spin_in = rdata_ff;
                     state_in    = ST_DONE;
                  end else begin
                     mem_addr = {row_up, col_ff};
                  end
               end
               3'd2: begin
                  ns_in    = ns_total;
                  mem_addr = {row_dn, col_ff};
               end
               3'd3: begin
                  ns_in    = ns_total;
                  mem_addr = {row_ff, col_lf};
               end
               3'd4: begin
                  ns_in    = ns_total;
                  mem_addr = {row_ff, col_rt};
               end
               default: begin
                  // last neighbour arrives: decide
                  res_acc_in  = dec.accepted;
                  res_de_in   = dec.energy_change;
                  res_spin_in = dec.accepted ? dec.spin_new : old_ff;
                  state_in    = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               out_spin_in  = res_spin_ff;
               out_acc_in   = res_acc_ff;
               out_de_in    = res_de_ff;
               out_err_in   = res_err_ff;
               rsp_valid_in = 1'b1;
               // write back an accepted proposal
               mem_we       = (cmd_ff == CMD_UPDATE) && res_acc_ff && !res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= SIZE_BITS'(MAX_ROWS);
         cols_ff      <= SIZE_BITS'(MAX_COLS);
         vac_ff       <= 5'sd1;
         thr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS:  rows_ff   <= csr_wdata[SIZE_BITS-1:0];
               CSR_COLS:  cols_ff   <= csr_wdata[SIZE_BITS-1:0];
               CSR_VAC:   vac_ff    <= csr_wdata[4:0];
               CSR_THR_A: thr_ff[0] <= csr_wdata;
               CSR_THR_B: thr_ff[1] <= csr_wdata;
               CSR_THR_C: thr_ff[2] <= csr_wdata;
               CSR_THR_D: thr_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      step_ff     <= step_in;
      rnd_ff      <= rnd_in;
      old_ff      <= old_in;
      ns_ff       <= ns_in;
      res_spin_ff <= res_spin_in;
      res_acc_ff  <= res_acc_in;
      res_de_ff   <= res_de_in;
      res_err_ff  <= res_err_in;
      out_spin_ff <= out_spin_in;
      out_acc_ff  <= out_acc_in;
      out_de_ff   <= out_de_in;
      out_err_ff  <= out_err_in;
   end

   // lattice: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lattice_mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= lattice_mem[mem_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spin_out      = out_spin_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_energy_change = out_de_ff;
   assign rsp_site_error    = out_err_ff;

endmodule
`default_nettype wire

[rtl/core/smu_decide.sv]
`default_nettype none
module smu_decide (
   input  wire logic signed [1:0]  old_spin,
   input  wire logic signed [3:0]  nbr_sum,
   input  wire logic               step_bit,
   input  wire logic signed [4:0]  vacancy_cost,
   input  wire smu_pkg::thr_bank_type thresholds,
   input  wire logic [15:0]        accept_random,
   output smu_pkg::decide_type     decision
);
   import smu_pkg::*;

   logic signed [2:0] old_w;
   logic signed [2:0] new_w;
   logic signed [2:0] diff;
   logic signed [2:0] sq_diff;
   logic signed [6:0] coupling;
   logic signed [6:0] vac_term;
   logic signed [6:0] de;
   logic [3:0]        thr_idx;
   logic [63:0]       thr_word;
   logic [THR_BITS-1:0] thr;
   logic              acc;

   always_comb begin
      // proposal: old + 1 + step, cycled back into {-1,0,+1}
      old_w = 3'(old_spin);
      new_w = old_w + 3'sd1 + $signed({2'b00, step_bit});
      if (new_w > 3'sd1) begin
         new_w = new_w - 3'sd3;
      end
      diff    = new_w - old_w;
      sq_diff = 3'(new_w * new_w) - 3'(old_w * old_w);

      // energy change: coupling to neighbours plus vacancy term
      coupling = 7'(nbr_sum) * 7'(diff);
      vac_term = 7'(vacancy_cost) * 7'(sq_diff);
      de       = vac_term - coupling;

      // threshold lookup, clamped at the largest tabulated change
      if (de > 7'(DE_MAX)) begin
         thr_idx = 4'(DE_MAX - 1);
      end else begin
         thr_idx = 4'(de - 7'sd1);
      end
      thr_word = thresholds[thr_idx[3:2]];
      thr      = thr_word[thr_idx[1:0]*THR_BITS +: THR_BITS];

      if (de <= 7'sd0) begin
         acc = 1'b1;
      end else begin
         acc = (accept_random[PROB_BITS-1:0] < thr[PROB_BITS-1:0]);
      end

      decision.spin_new      = new_w[1:0];
      decision.accepted      = acc;
      decision.energy_change = de[5:0];
   end

endmodule
`default_nettype wire
